[rtl/lpfr_pkg.sv]
// ============================================================================
// lpfr_pkg: shared definitions for the length-prefixed frame receiver
// Holds field widths, header constants and the header parser result type.
// ============================================================================
`default_nettype none

package lpfr_pkg;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 32;

    // Header window: three bytes held, the fourth completes a length.
    localparam int HDR_BYTES = 4;
    localparam int WIN_W     = (HDR_BYTES - 1) * BYTE_W;
    localparam int CNT_W     = 2;

    // Window holds a full set of three bytes.
    localparam logic [CNT_W-1:0] WIN_FULL = CNT_W'(HDR_BYTES - 1);

    // Reset value of the maximum body length register.
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(4096);

    // Result of the header parser for one beat.
    typedef struct packed {
        logic             done;    // a valid length was found on this beat
        logic [LEN_W-1:0] length;  // the announced body length
    } hdr_res_t;

endpackage

`default_nettype wire

[rtl/lpfr_stream_if.sv]
// ============================================================================
// lpfr_stream_if: valid/ready channels of the frame receiver
// lpfr_rx_if carries received link bytes; lpfr_body_if carries body bytes
// with frame marks and the announced frame length.
// ============================================================================
`default_nettype none

interface lpfr_rx_if;
    logic                        valid;
    logic                        ready;
    logic [lpfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfr_body_if;
    logic                        valid;
    logic                        ready;
    logic [lpfr_pkg::BYTE_W-1:0] data_byte;
    logic                        first_of_frame;
    logic                        last_of_frame;
    logic [lpfr_pkg::LEN_W-1:0]  frame_length;

    modport source (output valid, output data_byte, output first_of_frame,
                    output last_of_frame, output frame_length, input ready);
    modport sink   (input valid, input data_byte, input first_of_frame,
                    input last_of_frame, input frame_length, output ready);
endinterface

`default_nettype wire

[rtl/lpfr_hdr.sv]
// ============================================================================
// lpfr_hdr: big-endian length header parser
// Gathers header bytes into a 24-bit window. The fourth byte completes a
// candidate length; a zero or oversized length slides the window by one byte.
// ============================================================================
`default_nettype none

module lpfr_hdr (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [lpfr_pkg::BYTE_W-1:0] rx_byte,
    input  wire logic [lpfr_pkg::LEN_W-1:0]  max_len,
    output lpfr_pkg::hdr_res_t               res
);
    import lpfr_pkg::*;

    logic [WIN_W-1:0] win_reg;
    logic [WIN_W-1:0] win_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [LEN_W-1:0] cand_len;
    logic             cand_ok;

    // Candidate length formed by the held window and the current byte.
    assign cand_len = {win_reg, rx_byte};
    assign cand_ok  = (cand_len != '0) && (cand_len <= max_len);

    assign res.done   = step && (cnt_reg == WIN_FULL) && cand_ok;
    assign res.length = cand_len;

    // Window and count update for one header beat.
    always_comb
    begin
        win_next = win_reg;
        cnt_next = cnt_reg;
        if (step)
        begin
            if (cnt_reg != WIN_FULL)
            begin
                win_next = {win_reg[WIN_W-BYTE_W-1:0], rx_byte};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            else if (cand_ok)
            begin
                win_next = '0;
                cnt_next = '0;
            end
            else
            begin
                // Rejected length: keep the newest three bytes and retry.
                win_next = cand_len[WIN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/length_prefixed_frame_receiver.sv]
// ============================================================================
// length_prefixed_frame_receiver: 32-bit big-endian length-prefixed deframer
// Strips the four-byte length header from a byte stream and passes each body
// byte out with first/last marks and the frame length.
// ============================================================================
//
//   Channel       Dir  Beat contents
//   rx            in   rx_byte
//   body          out  data_byte, first_of_frame, last_of_frame, frame_length
//   max_len_we    in   max_len_wdata (maximum body length, reset 4096)
//
// One rx beat is accepted per clock. A body byte appears on the body channel
// the cycle after it is accepted, from a single output register; header bytes
// give no beat. rx is ready whenever the output register is empty or being
// drained, so a stall on body holds back rx by that one register only.
// Reset clears the header window, body counters and the output valid.
//
`default_nettype none

module length_prefixed_frame_receiver (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    lpfr_rx_if.sink                          rx,
    lpfr_body_if.source                      body,
    input  wire logic                        max_len_we,
    input  wire logic [lpfr_pkg::LEN_W-1:0]  max_len_wdata
);
    import lpfr_pkg::*;

    logic [LEN_W-1:0]  max_len_reg;
    logic              in_body_reg;
    logic              in_body_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [LEN_W-1:0]  recv_reg;
    logic [LEN_W-1:0]  recv_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_first_reg;
    logic              out_last_reg;
    logic [LEN_W-1:0]  out_len_reg;

    logic              accept;
    logic              body_beat;
    logic [LEN_W-1:0]  recv_inc;
    logic              is_first;
    logic              is_last;
    hdr_res_t          hdr_res;

    // Handshake: the output register parts the two sides.
    assign rx.ready  = !out_valid_reg || body.ready;
    assign accept    = rx.valid && rx.ready;
    assign body_beat = accept && in_body_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (max_len_we)
            max_len_reg <= max_len_wdata;
    end

    // Header parser sees only beats taken in header mode.
    lpfr_hdr u_hdr (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept && !in_body_reg),
        .rx_byte (rx.rx_byte),
        .max_len (max_len_reg),
        .res     (hdr_res)
    );

    // Body position marks.
    assign recv_inc = recv_reg + LEN_W'(1);
    assign is_first = (recv_reg == '0);
    assign is_last  = (recv_inc >= len_reg);

    // Mode and body counter update.
    always_comb
    begin
        in_body_next = in_body_reg;
        len_next     = len_reg;
        recv_next    = recv_reg;
        if (hdr_res.done)
        begin
            in_body_next = 1'b1;
            len_next     = hdr_res.length;
            recv_next    = '0;
        end
        else if (body_beat)
        begin
            if (is_last)
            begin
                in_body_next = 1'b0;
                len_next     = '0;
                recv_next    = '0;
            end
            else
            begin
                recv_next = recv_inc;
            end
        end
    end

    // Output valid: set by a body beat, cleared when the sink takes it.
    always_comb
    begin
        if (body_beat)
            out_valid_next = 1'b1;
        else if (body.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg   <= 1'b0;
            len_reg       <= '0;
            recv_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_body_reg   <= in_body_next;
            len_reg       <= len_next;
            recv_reg      <= recv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register, loaded on each body beat.
    always_ff @(posedge clk)
    begin
        if (body_beat)
        begin
            out_byte_reg  <= rx.rx_byte;
            out_first_reg <= is_first;
            out_last_reg  <= is_last;
            out_len_reg   <= len_reg;
        end
    end

    assign body.valid          = out_valid_reg;
    assign body.data_byte      = out_byte_reg;
    assign body.first_of_frame = out_first_reg;
    assign body.last_of_frame  = out_last_reg;
    assign body.frame_length   = out_len_reg;

endmodule

`default_nettype wire
